/* design/oqkr_pkg.sv */
// Package for the ordered queue with keyed remove.
// Holds mode and status codes used by the top level and field widths shared with the interfaces.
package oqkr_pkg;
   localparam logic [2:0] MODE_APPEND = 3'd0;
   localparam logic [2:0] MODE_POP    = 3'd1;
   localparam logic [2:0] MODE_REMOVE = 3'd2;
   localparam logic [2:0] MODE_LOOKUP = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int HANDLE_BITS = 16;
   localparam int KEY_BITS    = 16;
endpackage

/* design/oqkr_if.sv */
// Valid/ready channel interfaces for the ordered queue.
// Depends on oqkr_pkg for field widths.
interface oqkr_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       mode;
   logic [oqkr_pkg::KEY_BITS-1:0]    key_id;
   logic [oqkr_pkg::HANDLE_BITS-1:0] entry_handle;
   modport source (output valid, mode, key_id, entry_handle, input ready);
   modport sink   (input valid, mode, key_id, entry_handle, output ready);
endinterface

interface oqkr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [oqkr_pkg::KEY_BITS-1:0]    out_id;
   logic [oqkr_pkg::HANDLE_BITS-1:0] out_handle;
   logic [4:0]                       count;
   modport source (output valid, status, out_id, out_handle, count, input ready);
   modport sink   (input valid, status, out_id, out_handle, count, output ready);
endinterface

/* design/ordered_queue_keyed_remove.sv */
// Top level of the ordered queue with keyed remove.
// Depends on oqkr_pkg and the channel interfaces in oqkr_if.sv.
//
// Usage: items enter on req (mode, key_id, entry_handle); each gives one
// result on rsp (status, out_id, out_handle, count).
// The queue lives in a circular memory addressed by a head pointer.
// Append, clear, undefined modes and any operation on an empty queue go
// straight to the done state, which registers the result; pop first reads the head entry.
// Lookup reads one entry a cycle from the head until an entry matches or
// all n entries have been read without a match.
// Remove does the same search and then shifts each of the m later entries one
// place towards the head through the single read port, one read and one write
// per entry (no shift when the entry was at the head or the tail).
// One item is worked on at a time; req.ready is high only while idle with the
// result register empty or being taken in the same cycle, so a stalled
// receiver holds the result and blocks new items. The next item can enter in
// the cycle in which the result is taken.
// Reset empties the queue at once; memory contents are left as they are and
// only entries below the count are ever read.
module ordered_queue_keyed_remove #(
   parameter int CAPACITY = 16,
   parameter int ID_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   oqkr_req_if.sink    req,
   oqkr_rsp_if.source  rsp
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = ID_BITS + oqkr_pkg::HANDLE_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;
   localparam logic [2:0] S_SHRD  = 3'd2;
   localparam logic [2:0] S_SHWR  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [DW-1:0] mem [CAPACITY];
   logic [DW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] pos_ff, pos_in;      // logical index being read
   logic [2:0]    mode_ff, mode_in;
   logic [ID_BITS-1:0] key_ff, key_in;
   logic [1:0]    st_ff, st_in;
   logic [DW-1:0] res_ff, res_in;
   logic          rv_ff, rv_in;
   logic [1:0]    ost_ff, ost_in;
   logic [DW-1:0] ores_ff, ores_in;
   logic [CW-1:0] ocnt_ff, ocnt_in;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] p);
      logic [CW:0] s;
      s = {{(CW+1-AW){1'b0}}, h} + {1'b0, p};
      if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
      return s[AW-1:0];
   endfunction

   assign req.ready = (state_ff == S_IDLE) && (!rv_ff || rsp.ready);
   wire accept = req.valid && req.ready;

   always_comb begin
      state_in = state_ff; head_in = head_ff; occ_in = occ_ff; pos_in = pos_ff;
      mode_in = mode_ff; key_in = key_ff; st_in = st_ff; res_in = res_ff;
      rv_in = rv_ff; ost_in = ost_ff; ores_in = ores_ff; ocnt_in = ocnt_ff;
      rd_en = 1'b0; rd_addr = phys(head_ff, pos_ff);
      wr_en = 1'b0; wr_addr = phys(head_ff, pos_ff); wr_data = rd_data_ff;
      if (rsp.valid && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: if (accept) begin
            mode_in = req.mode; key_in = ID_BITS'(req.key_id);
            st_in = oqkr_pkg::ST_MISS; res_in = '0; pos_in = '0;
            state_in = S_DONE;
            case (req.mode)
               oqkr_pkg::MODE_APPEND: begin
                  if (occ_ff < CW'(CAPACITY)) begin
                     wr_en = 1'b1; wr_addr = phys(head_ff, occ_ff);
                     wr_data = {ID_BITS'(req.key_id), req.entry_handle};
                     occ_in = occ_ff + 1'b1; st_in = oqkr_pkg::ST_OK;
                  end else st_in = oqkr_pkg::ST_FULL;
               end
               oqkr_pkg::MODE_CLEAR: begin
                  occ_in = '0; st_in = oqkr_pkg::ST_OK;
               end
               oqkr_pkg::MODE_POP, oqkr_pkg::MODE_REMOVE, oqkr_pkg::MODE_LOOKUP:
                  if (occ_ff != '0) begin
                     rd_en = 1'b1; rd_addr = phys(head_ff, '0); state_in = S_SRCH;
                  end
               default: ;
            endcase
         end
         S_SRCH: begin
            // rd_data_ff holds the entry at pos_ff.
            if (mode_ff == oqkr_pkg::MODE_POP ||
                rd_data_ff[DW-1 -: ID_BITS] == key_ff) begin
               st_in = oqkr_pkg::ST_OK; res_in = rd_data_ff;
               if (mode_ff == oqkr_pkg::MODE_LOOKUP) state_in = S_DONE;
               else if (pos_ff == '0) begin
                  head_in = phys(head_ff, CW'(1)); occ_in = occ_ff - 1'b1;
                  state_in = S_DONE;
               end else if (pos_ff + 1'b1 >= occ_ff) begin
                  occ_in = occ_ff - 1'b1; state_in = S_DONE;
               end else begin
                  rd_en = 1'b1; rd_addr = phys(head_ff, pos_ff + 1'b1);
                  state_in = S_SHWR;
               end
            end else if (pos_ff + 1'b1 >= occ_ff) state_in = S_DONE;
            else begin
               pos_in = pos_ff + 1'b1; rd_en = 1'b1;
               rd_addr = phys(head_ff, pos_ff + 1'b1);
            end
         end
         S_SHWR: begin
            // Move the entry after pos_ff down into pos_ff.
            wr_en = 1'b1; wr_addr = phys(head_ff, pos_ff);
            pos_in = pos_ff + 1'b1;
            if (pos_ff + CW'(2) >= occ_ff) begin
               occ_in = occ_ff - 1'b1; state_in = S_DONE;
            end else state_in = S_SHRD;
         end
         S_SHRD: begin
            rd_en = 1'b1; rd_addr = phys(head_ff, pos_ff + 1'b1); state_in = S_SHWR;
         end
         S_DONE: begin
            rv_in = 1'b1; ost_in = st_ff; ores_in = res_ff; ocnt_in = occ_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= '0; occ_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; occ_ff <= occ_in; rv_ff <= rv_in;
      end
      pos_ff <= pos_in; mode_ff <= mode_in; key_ff <= key_in; st_ff <= st_in;
      res_ff <= res_in; ost_ff <= ost_in; ores_ff <= ores_in; ocnt_ff <= ocnt_in;
   end

   assign rsp.valid      = rv_ff;
   assign rsp.status     = ost_ff;
   assign rsp.out_id     = oqkr_pkg::KEY_BITS'(ores_ff[DW-1 -: ID_BITS]);
   assign rsp.out_handle = ores_ff[oqkr_pkg::HANDLE_BITS-1:0];
   assign rsp.count      = 5'(ocnt_ff);

`ifndef ASSERT_OFF
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY)) else $error("occupancy above capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(ocnt_ff)))
      else $error("result dropped while stalled");
`endif
endmodule
